// File: sv/fcwmmm_pkg.sv
// Shared constants, types and state codes of the four-channel window statistics unit.
`default_nettype none
package fcwmmm_pkg;

  localparam int CHANNELS  = 4;
  localparam int MAX_FRAME = 1024;
  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 34;
  localparam int LEN_W     = 11;
  localparam int CNT_W     = LEN_W;
  localparam int REM_W     = CNT_W + 1;
  localparam int BIT_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = CHANNELS * SAMPLE_W;
  localparam int OUT_W     = 3 * CHANNELS * SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] CODE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] CODE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  localparam logic [BIT_W-1:0] STEP_LAST = BIT_W'(SUM_W - 1);
  localparam logic [BIT_W-1:0] STEP_MSB  = BIT_W'(SAMPLE_W - 1);
  localparam logic [BIT_W-1:0] STEP_ROT  = BIT_W'(SAMPLE_W);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_NEG,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic acc_step;
    logic rot;
    logic msb;
    logic neg_load;
    logic div_step;
    logic clear;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// File: sv/fcwmmm_lane.sv
// One channel: bit-serial sum, min and max tracking and a bit-serial restoring divider.
`default_nettype none
module fcwmmm_lane (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fcwmmm_pkg::lane_ctrl_t             ctrl,
  input  wire logic [fcwmmm_pkg::SAMPLE_W-1:0]    sample_in,
  input  wire logic [fcwmmm_pkg::CNT_W-1:0]       divisor,
  output logic      [fcwmmm_pkg::SAMPLE_W-1:0]    avg_sm,
  output logic      [fcwmmm_pkg::SAMPLE_W-1:0]    min_sm,
  output logic      [fcwmmm_pkg::SAMPLE_W-1:0]    max_sm
);

  logic [fcwmmm_pkg::SAMPLE_W-1:0] samp_r, samp_nxt;
  logic                            sign_r, sign_nxt;
  logic [fcwmmm_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                            carry_r, carry_nxt;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] min_r, min_nxt;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic                            lt_r, lt_nxt;
  logic                            gt_r, gt_nxt;
  logic                            neg_r, neg_nxt;
  logic [fcwmmm_pkg::REM_W-1:0]    rem_r, rem_nxt;

  logic                            s_bit;
  logic                            sum_bit;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] samp_rot;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] min_rot;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] max_rot;
  logic                            lt_step;
  logic                            gt_step;
  logic [fcwmmm_pkg::REM_W-1:0]    trial;
  logic [fcwmmm_pkg::REM_W-1:0]    div_ext;
  logic                            ge;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] min_neg;
  logic [fcwmmm_pkg::SAMPLE_W-1:0] max_neg;

  always_comb begin
    s_bit    = ctrl.rot ? samp_r[0] : sign_r;
    sum_bit  = sum_r[0] ^ s_bit ^ carry_r;
    samp_rot = {samp_r[0], samp_r[fcwmmm_pkg::SAMPLE_W-1:1]};
    min_rot  = {min_r[0], min_r[fcwmmm_pkg::SAMPLE_W-1:1]};
    max_rot  = {max_r[0], max_r[fcwmmm_pkg::SAMPLE_W-1:1]};
    lt_step  = (s_bit != min_r[0]) ? (ctrl.msb ? s_bit : ~s_bit) : lt_r;
    gt_step  = (s_bit != max_r[0]) ? (ctrl.msb ? ~s_bit : s_bit) : gt_r;
    trial    = {rem_r[fcwmmm_pkg::CNT_W-1:0], sum_r[fcwmmm_pkg::SUM_W-1]};
    div_ext  = {1'b0, divisor};
    ge       = trial >= div_ext;

    samp_nxt  = samp_r;
    sign_nxt  = sign_r;
    sum_nxt   = sum_r;
    carry_nxt = carry_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    lt_nxt    = lt_r;
    gt_nxt    = gt_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;

    if (ctrl.clear) begin
      sum_nxt = '0;
      min_nxt = fcwmmm_pkg::CODE_MAX;
      max_nxt = fcwmmm_pkg::CODE_MIN;
    end else if (ctrl.load) begin
      samp_nxt  = sample_in;
      sign_nxt  = sample_in[fcwmmm_pkg::SAMPLE_W-1];
      carry_nxt = 1'b0;
      lt_nxt    = 1'b0;
      gt_nxt    = 1'b0;
    end else if (ctrl.acc_step) begin
      sum_nxt   = {sum_bit, sum_r[fcwmmm_pkg::SUM_W-1:1]};
      carry_nxt = (sum_r[0] & s_bit) | (carry_r & (sum_r[0] ^ s_bit));
      if (ctrl.rot) begin
        samp_nxt = samp_rot;
        lt_nxt   = lt_step;
        gt_nxt   = gt_step;
        if (ctrl.msb) begin
          min_nxt = lt_step ? samp_rot : min_rot;
          max_nxt = gt_step ? samp_rot : max_rot;
        end else begin
          min_nxt = min_rot;
          max_nxt = max_rot;
        end
      end
    end else if (ctrl.neg_load) begin
      neg_nxt = sum_r[fcwmmm_pkg::SUM_W-1];
      sum_nxt = sum_r[fcwmmm_pkg::SUM_W-1] ? -sum_r : sum_r;
      rem_nxt = '0;
    end else if (ctrl.div_step) begin
      rem_nxt = ge ? (trial - div_ext) : trial;
      sum_nxt = {sum_r[fcwmmm_pkg::SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= fcwmmm_pkg::CODE_MAX;
      max_r <= fcwmmm_pkg::CODE_MIN;
    end else begin
      sum_r <= sum_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r  <= samp_nxt;
    sign_r  <= sign_nxt;
    carry_r <= carry_nxt;
    lt_r    <= lt_nxt;
    gt_r    <= gt_nxt;
    neg_r   <= neg_nxt;
    rem_r   <= rem_nxt;
  end

  always_comb begin
    min_neg = -min_r;
    max_neg = -max_r;
    if (divisor == '0) begin
      avg_sm = {neg_r, {(fcwmmm_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      avg_sm = {neg_r, sum_r[fcwmmm_pkg::SAMPLE_W-2:0]};
    end
    min_sm = min_r[fcwmmm_pkg::SAMPLE_W-1] ?
             {1'b1, min_neg[fcwmmm_pkg::SAMPLE_W-2:0]} :
             {1'b0, min_r[fcwmmm_pkg::SAMPLE_W-2:0]};
    max_sm = max_r[fcwmmm_pkg::SAMPLE_W-1] ?
             {1'b1, max_neg[fcwmmm_pkg::SAMPLE_W-2:0]} :
             {1'b0, max_r[fcwmmm_pkg::SAMPLE_W-2:0]};
  end

endmodule
`default_nettype wire

// File: sv/four_channel_window_min_max_mean_unit.sv
// Top level of the four-channel window min, max and mean unit.
// Each transaction on the input carries one 24-bit sample per channel. Frames are N
// transactions long; the first half is discarded and the rest is folded into per-channel
// running sum, minimum and maximum, all processed LSB first one bit per cycle in shift
// registers. A kept sample occupies the block for its accept and the serial bit steps
// set by the 34-bit sum; a discarded or disabled one is only accepted. The
// frame-ending sample adds a step for the sum magnitude, the bit-serial restoring
// division by the kept count, and the load of the result register, which may
// wait while an earlier result is still pending. Results are sign-magnitude. The
// configuration channel is always ready.
`default_nettype none
module four_channel_window_min_max_mean_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // sample_a, sample_b, sample_c, sample_d
  input  wire logic [fcwmmm_pkg::IN_W-1:0]         in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // avg_a, avg_b, avg_c, avg_d, min_a, min_b, min_c, min_d, max_a, max_b, max_c, max_d
  output logic      [fcwmmm_pkg::OUT_W-1:0]        out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fcwmmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fcwmmm_pkg::LEN_W-1:0]        cfg_data
);

  fcwmmm_pkg::state_t state_r, state_nxt;
  logic [fcwmmm_pkg::BIT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [fcwmmm_pkg::LEN_W-1:0] pos_r, pos_nxt;
  logic [fcwmmm_pkg::CNT_W-1:0] kept_r, kept_nxt;
  logic                         last_r, last_nxt;
  logic                         enable_r;
  logic [fcwmmm_pkg::LEN_W-1:0] frame_len_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [fcwmmm_pkg::OUT_W-1:0] out_data_r;

  logic [fcwmmm_pkg::LEN_W-1:0] n_eff;
  logic [fcwmmm_pkg::LEN_W-1:0] pos_inc;
  logic                         keep;
  logic                         last;
  logic                         accept;
  logic                         take;
  logic                         out_free;
  logic                         out_load;
  fcwmmm_pkg::lane_ctrl_t       ctrl;

  logic [fcwmmm_pkg::CHANNELS-1:0][fcwmmm_pkg::SAMPLE_W-1:0] avg_sm;
  logic [fcwmmm_pkg::CHANNELS-1:0][fcwmmm_pkg::SAMPLE_W-1:0] min_sm;
  logic [fcwmmm_pkg::CHANNELS-1:0][fcwmmm_pkg::SAMPLE_W-1:0] max_sm;
  logic [fcwmmm_pkg::OUT_W-1:0] result;

  always_comb begin
    if (frame_len_r == '0) begin
      n_eff = fcwmmm_pkg::LEN_ONE;
    end else if (frame_len_r > fcwmmm_pkg::LEN_MAX) begin
      n_eff = fcwmmm_pkg::LEN_MAX;
    end else begin
      n_eff = frame_len_r;
    end
    pos_inc  = pos_r + fcwmmm_pkg::LEN_ONE;
    keep     = pos_r >= (n_eff >> 1);
    last     = pos_inc >= n_eff;
    accept   = in_tvalid && in_tready;
    take     = accept && enable_r;
    out_free = !out_valid_r || out_tready;
    out_load = (state_r == fcwmmm_pkg::ST_OUT) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcwmmm_pkg::ST_IDLE: begin
        if (take) begin
          if (keep) begin
            state_nxt = fcwmmm_pkg::ST_ACC;
          end else if (last) begin
            state_nxt = fcwmmm_pkg::ST_NEG;
          end
        end
      end
      fcwmmm_pkg::ST_ACC: begin
        if (bit_cnt_r == fcwmmm_pkg::STEP_LAST) begin
          state_nxt = last_r ? fcwmmm_pkg::ST_NEG : fcwmmm_pkg::ST_IDLE;
        end
      end
      fcwmmm_pkg::ST_NEG: begin
        state_nxt = fcwmmm_pkg::ST_DIV;
      end
      fcwmmm_pkg::ST_DIV: begin
        if (bit_cnt_r == fcwmmm_pkg::STEP_LAST) begin
          state_nxt = fcwmmm_pkg::ST_OUT;
        end
      end
      fcwmmm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = fcwmmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcwmmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = state_r == fcwmmm_pkg::ST_IDLE;
    cfg_ready     = 1'b1;
    ctrl.load     = take && keep;
    ctrl.acc_step = state_r == fcwmmm_pkg::ST_ACC;
    ctrl.rot      = bit_cnt_r < fcwmmm_pkg::STEP_ROT;
    ctrl.msb      = bit_cnt_r == fcwmmm_pkg::STEP_MSB;
    ctrl.neg_load = state_r == fcwmmm_pkg::ST_NEG;
    ctrl.div_step = state_r == fcwmmm_pkg::ST_DIV;
    ctrl.clear    = out_load;

    bit_cnt_nxt = (state_nxt != state_r) ? '0 : bit_cnt_r + 1'b1;
    pos_nxt     = pos_r;
    kept_nxt    = kept_r;
    last_nxt    = last_r;
    if (out_load) begin
      pos_nxt  = '0;
      kept_nxt = '0;
    end else if (take) begin
      pos_nxt  = pos_inc;
      last_nxt = last;
      if (keep) begin
        kept_nxt = kept_r + fcwmmm_pkg::LEN_ONE;
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  for (genvar c = 0; c < fcwmmm_pkg::CHANNELS; c++) begin : g_lane
    fcwmmm_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sample_in (in_tdata[c*fcwmmm_pkg::SAMPLE_W +: fcwmmm_pkg::SAMPLE_W]),
      .divisor   (kept_r),
      .avg_sm    (avg_sm[c]),
      .min_sm    (min_sm[c]),
      .max_sm    (max_sm[c])
    );
  end

  always_comb begin
    result = {max_sm, min_sm, avg_sm};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcwmmm_pkg::ST_IDLE;
      bit_cnt_r   <= '0;
      pos_r       <= '0;
      kept_r      <= '0;
      last_r      <= 1'b0;
      enable_r    <= 1'b0;
      frame_len_r <= fcwmmm_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      pos_r       <= pos_nxt;
      kept_r      <= kept_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fcwmmm_pkg::REG_ENABLE:    enable_r    <= cfg_data[0];
          fcwmmm_pkg::REG_FRAME_LEN: frame_len_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcwmmm_pkg::ST_DIV) && (bit_cnt_r == fcwmmm_pkg::STEP_LAST)
    |=> (state_r == fcwmmm_pkg::ST_OUT))
    else $error("divider did not hand over to the output state");

  a_kept_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= pos_r)
    else $error("kept count exceeds frame position");

  a_kept_max: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= fcwmmm_pkg::LEN_MAX)
    else $error("kept count exceeds the largest frame");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fcwmmm_pkg::ST_OUT))
    else $error("result raised outside the output state");
`endif

endmodule
`default_nettype wire

// File: dv/tb_four_channel_window_min_max_mean_unit.sv
// Self-checking testbench for the four-channel window min, max and mean unit.
module tb_four_channel_window_min_max_mean_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fcwmmm_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [LEN_W-1:0] LEN_ABOVE_MAX = '1;

  class window_stats_tracker;
    logic                       enable;
    logic [LEN_W-1:0]           frame_len;
    int unsigned                position;
    int unsigned                kept;
    logic signed [SAMPLE_W-1:0] lo [CHANNELS];
    logic signed [SAMPLE_W-1:0] hi [CHANNELS];
    logic signed [SUM_W-1:0]    acc [CHANNELS];
    logic [OUT_W-1:0]           pending_stats [$];
    int                         errors;
    int                         results;
    int                         samples;
    int                         ignored;

    function new();
      enable    = 1'b0;
      frame_len = LEN_RESET;
      errors    = 0;
      results   = 0;
      samples   = 0;
      ignored   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      position = 0;
      kept     = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        lo[c]  = CODE_MAX;
        hi[c]  = CODE_MIN;
        acc[c] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      if (idx == REG_ENABLE) begin
        enable = data[0];
      end else begin
        frame_len = data;
      end
    endfunction

    function logic [SAMPLE_W-1:0] sign_mag_code(logic signed [SAMPLE_W-1:0] v);
      logic signed [SAMPLE_W:0] w;
      w = v;
      if (v < 0) begin
        w = -w;
        return {1'b1, w[SAMPLE_W-2:0]};
      end
      return {1'b0, v[SAMPLE_W-2:0]};
    endfunction

    function void note_sample(logic [IN_W-1:0] d);
      int unsigned                n;
      logic signed [SAMPLE_W-1:0] s;
      logic [SUM_W-1:0]           mag;
      logic [SUM_W-1:0]           q;
      logic                       neg;
      logic [OUT_W-1:0]           stats;
      samples++;
      if (!enable) begin
        ignored++;
        return;
      end
      n = frame_len;
      if (n == 0) n = 1;
      if (n > MAX_FRAME) n = MAX_FRAME;
      if (position >= n / 2) begin
        for (int c = 0; c < CHANNELS; c++) begin
          s = d[c*SAMPLE_W +: SAMPLE_W];
          if (s < lo[c]) lo[c] = s;
          if (s > hi[c]) hi[c] = s;
          acc[c] = acc[c] + s;
        end
        kept++;
      end
      position++;
      if (position < n) return;
      for (int c = 0; c < CHANNELS; c++) begin
        neg = acc[c] < 0;
        mag = neg ? -acc[c] : acc[c];
        q   = (kept != 0) ? mag / SUM_W'(kept) : '0;
        stats[c*SAMPLE_W +: SAMPLE_W]              = {neg, q[SAMPLE_W-2:0]};
        stats[(CHANNELS+c)*SAMPLE_W +: SAMPLE_W]   = sign_mag_code(lo[c]);
        stats[(2*CHANNELS+c)*SAMPLE_W +: SAMPLE_W] = sign_mag_code(hi[c]);
      end
      pending_stats.insert(pending_stats.size(), stats);
      clear_frame();
    endfunction

    function void check_stats(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      string            kinds [3];
      string            lanes;
      kinds   = '{"avg", "min", "max"};
      lanes   = "abcd";
      results++;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_stats.pop_front();
      for (int f = 0; f < 3 * CHANNELS; f++) begin
        if (got[f*SAMPLE_W +: SAMPLE_W] !== want[f*SAMPLE_W +: SAMPLE_W]) begin
          errors++;
          $display("%0t: %s_%c mismatch, expected %h, actual %h", $time,
                   kinds[f / CHANNELS], lanes[f % CHANNELS],
                   want[f*SAMPLE_W +: SAMPLE_W], got[f*SAMPLE_W +: SAMPLE_W]);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;

  window_stats_tracker tracker;
  int                  send_idle_pct = 14;
  int                  recv_idle_pct = 59;
  int                  cycles = 0;
  int                  settings = 0;

  four_channel_window_min_max_mean_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_samples(logic [SAMPLE_W-1:0] a,
                                                   logic [SAMPLE_W-1:0] b,
                                                   logic [SAMPLE_W-1:0] c,
                                                   logic [SAMPLE_W-1:0] d);
    return {d, c, b, a};
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_code();
    case ($urandom_range(15))
      0: return CODE_MIN;
      1: return CODE_MAX;
      2: return '0;
      3: return '1;
      4: return SAMPLE_W'($urandom_range(32)) - SAMPLE_W'(16);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_samples();
    return pack_samples(random_code(), random_code(), random_code(), random_code());
  endfunction

  task automatic send_sample(input logic [IN_W-1:0] d);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    tracker.note_sample(d);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_enable(input logic en);
    logic [LEN_W-1:0] data;
    data    = LEN_W'($urandom);
    data[0] = en;
    write_reg(REG_ENABLE, data);
  endtask

  task automatic set_frame_len(input logic [LEN_W-1:0] len);
    write_reg(REG_FRAME_LEN, len);
    settings++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (tracker.pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_stats(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int               rand_sent;
    int               count;
    int unsigned      pick;
    logic [LEN_W-1:0] len;
    tracker   = new();
    rand_sent = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_enable(1'b0);
    send_sample(pack_samples(CODE_MAX, CODE_MIN, '0, '1));
    send_sample(random_samples());

    settle();
    set_frame_len(LEN_ONE);
    set_enable(1'b1);
    send_sample(pack_samples(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX));
    send_sample(pack_samples(CODE_MIN, CODE_MIN, CODE_MIN, CODE_MIN));
    send_sample(pack_samples('0, '1, SAMPLE_W'(1), 24'hAAAAAA));
    send_sample(pack_samples(24'h555555, 24'hFFFFFE, CODE_MIN, CODE_MAX));

    settle();
    set_frame_len('0);
    send_sample(pack_samples(CODE_MIN, CODE_MAX, '1, '0));

    settle();
    set_frame_len(LEN_W'(4));
    send_sample(random_samples());
    send_sample(random_samples());
    send_sample(pack_samples('1, CODE_MIN, CODE_MAX, SAMPLE_W'(1)));
    send_sample(pack_samples('0, CODE_MIN, CODE_MAX, 24'hFFFFFE));

    settle();
    set_frame_len(LEN_W'(3));
    send_sample(pack_samples(CODE_MIN, CODE_MIN, CODE_MIN, CODE_MIN));
    send_sample(pack_samples(CODE_MAX, '1, '0, SAMPLE_W'(7)));
    send_sample(pack_samples(CODE_MIN, '1, '0, 24'hFFFFF9));

    settle();
    set_frame_len(LEN_MAX);
    repeat (5) send_sample(random_samples());
    settle();
    set_frame_len(LEN_W'(3));
    send_sample(random_samples());

    settle();
    set_frame_len(LEN_W'(4));
    repeat (2) send_sample(random_samples());
    settle();
    set_enable(1'b0);
    repeat (2) send_sample(random_samples());
    settle();
    set_enable(1'b1);
    repeat (2) send_sample(random_samples());

    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 59;
      end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      pick = $urandom_range(99);
      if (pick < 50) len = LEN_W'($urandom_range(8, 1));
      else if (pick < 85) len = LEN_W'($urandom_range(40, 9));
      else if (pick < 95) len = LEN_W'($urandom_range(3, 0));
      else len = LEN_W'($urandom_range(100, 41));
      set_frame_len(len);
      if ($urandom_range(9) == 0) begin
        set_enable(1'b0);
        repeat ($urandom_range(10, 3)) send_sample(random_samples());
        settle();
        set_enable(1'b1);
      end
      count = $urandom_range(60, 5);
      repeat (count) send_sample(random_samples());
      rand_sent += count;
    end

    settle();
    set_frame_len(LEN_ONE);
    send_sample(random_samples());
    settle();
    set_frame_len(LEN_ABOVE_MAX);
    repeat (4) send_sample(pack_samples(CODE_MIN, CODE_MAX, random_code(),
                                        SAMPLE_W'($urandom)));
    settle();
    set_frame_len(LEN_W'(3));
    send_sample(random_samples());

    settle();
    $display("Sent %0d samples (%0d ignored while disabled), checked %0d statistics results,",
             tracker.samples, tracker.ignored, tracker.results);
    $display("across %0d frame-length settings from zero up to the saturated maximum.",
             settings);
    if (tracker.errors == 0 && tracker.pending_stats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
